@@ hdl/bba_pkg.sv @@
package bba_pkg;

   // Default pool size in minimum blocks.
   localparam int POOL_BLOCKS_DEF = 256;

   // Fixed field widths.
   localparam int BYTE_W     = 24;
   localparam int ORDER_W    = 4;
   localparam int FREE_W     = 9;
   localparam int STAT_W     = 2;
   localparam int SHIFT_W    = 5;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Register map: word select bit of paddr.
   localparam logic REG_BLOCK_SHIFT = 1'b0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OOM       = 2'd1,
      STAT_NOT_ALLOC = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_LOOK,
      S_CHECK,
      S_DREAD,
      S_DDATA,
      S_BOOK,
      S_UWRITE,
      S_USIB,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic prep;
      logic look;
      logic check;
      logic dread;
      logic ddata;
      logic book;
      logic uwrite;
      logic usib;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic is_free;
      logic fail;
      logic at_target;
      logic desc_done;
      logic at_root;
   } dp_stat_type;

   // Smallest c with 2^c >= v; zero and one give zero.
   function automatic logic [4:0] ceil_log2_24(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] m;
      logic [4:0]        r;
      m = v - BYTE_W'(1);
      r = 5'd0;
      if (v > BYTE_W'(1)) begin
         for (int i = 0; i < BYTE_W; i++) begin
            if (m[i]) r = 5'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/bba_ifs.sv @@
// Request channel: one allocate or free per beat.
interface bba_req_if
   import bba_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] request_bytes;
   logic [BYTE_W-1:0] free_offset;

   modport source (output valid, op, request_bytes, free_offset, input ready);
   modport sink   (input valid, op, request_bytes, free_offset, output ready);
endinterface

// Response channel: one result per beat.
interface bba_rsp_if
   import bba_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [BYTE_W-1:0]  granted_offset;
   logic [ORDER_W-1:0] granted_order;
   logic [FREE_W-1:0]  free_blocks;

   modport source (output valid, status, granted_offset, granted_order, free_blocks,
                   input ready);
   modport sink   (input valid, status, granted_offset, granted_order, free_blocks,
                   output ready);
endinterface

@@ hdl/bba_ram.sv @@
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/bba_ctrl.sv @@
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   // Sequencing: clear, look up, descend the tree, book, walk back to the root.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.fail)                           state_in = S_RESP;
            else if (stat.is_free || stat.at_target) state_in = S_BOOK;
            else                                     state_in = S_DREAD;
         end
         S_DREAD: begin
            cmd.dread = 1'b1;
            state_in  = S_DDATA;
         end
         S_DDATA: begin
            cmd.ddata = 1'b1;
            state_in  = stat.desc_done ? S_BOOK : S_DREAD;
         end
         S_BOOK: begin
            cmd.book = 1'b1;
            state_in = S_UWRITE;
         end
         S_UWRITE: begin
            cmd.uwrite = 1'b1;
            state_in   = stat.at_root ? S_RESP : S_USIB;
         end
         S_USIB: begin
            cmd.usib = 1'b1;
            state_in = S_UWRITE;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ hdl/bba_dp.sv @@
module bba_dp
   import bba_pkg::*;
#(
   parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] block_shift,
   input  logic               req_op,
   input  logic [BYTE_W-1:0]  req_request_bytes,
   input  logic [BYTE_W-1:0]  req_free_offset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [BYTE_W-1:0]  rsp_granted_offset,
   output logic [ORDER_W-1:0] rsp_granted_order,
   output logic [FREE_W-1:0]  rsp_free_blocks
);
   // Tree geometry: orders 0..PO, heap-ordered nodes 1..2^(PO+1)-1.
   localparam int PO    = $clog2(POOL_BLOCKS + 1) - 1;
   localparam int NW    = PO + 1;
   localparam int MW    = PO + 1;
   localparam int BW    = PO;
   localparam int FCW   = $clog2(POOL_BLOCKS + 1);
   localparam int SHW   = BW + 32;
   localparam int NODES = 2 ** NW;
   localparam int BLKS  = 2 ** BW;
   localparam int AW    = ORDER_W + 1;

   // Captured request and working registers.
   logic               op_ff;
   logic [BYTE_W-1:0]  bytes_ff, off_ff;
   logic [ORDER_W-1:0] k_ff, ot_ff, o_ff;
   logic               oom_ff, bad_ff, merge_ff;
   logic [BW-1:0]      blk_ff;
   logic [NW-1:0]      cur_ff, clr_ff;
   logic [MW-1:0]      val_ff;
   logic [FCW-1:0]     fc_ff;
   status_type         stat_ff;
   logic [BYTE_W-1:0]  goff_ff;
   logic [ORDER_W-1:0] gord_ff;
   logic [FREE_W-1:0]  gfree_ff;

   // Memory ports. Each node holds a mask of the free orders in its subtree.
   logic          node_we, alloc_we;
   logic [NW-1:0] node_wa, node_ra;
   logic [MW-1:0] node_wd, node_rd;
   logic [BW-1:0] alloc_wa;
   logic [AW-1:0] alloc_wd, alloc_rd;

   bba_ram #(.WIDTH(MW), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd)
   );

   // Each entry holds {allocation starts here, order}.
   bba_ram #(.WIDTH(AW), .DEPTH(BLKS)) u_alloc_ram (
      .clock(clock), .wr_en(alloc_we), .wr_addr(alloc_wa), .wr_data(alloc_wd),
      .rd_addr(blk_ff), .rd_data(alloc_rd)
   );

   // Size rounding and free offset checks.
   logic [4:0]          clog_c, kfull;
   logic [BYTE_W-1:0]   low_mask, shifted;
   logic                oob;
   always_comb begin
      clog_c   = ceil_log2_24(bytes_ff);
      kfull    = (clog_c > block_shift) ? clog_c - block_shift : 5'd0;
      low_mask = ~({BYTE_W{1'b1}} << block_shift);
      shifted  = off_ff >> block_shift;
      oob      = (shifted >> BW) != '0;
   end

   // Lowest free order at or above the request, from the root mask.
   logic [MW-1:0]      cand;
   logic [ORDER_W-1:0] ot_c;
   logic               found;
   always_comb begin
      cand  = node_rd & ({MW{1'b1}} << k_ff);
      ot_c  = '0;
      found = 1'b0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (cand[i]) begin
            ot_c  = ORDER_W'(i);
            found = 1'b1;
         end
      end
   end

   // Lookup results and status.
   logic               a_start;
   logic [ORDER_W-1:0] a_order, kf;
   logic               fail, go_left;
   always_comb begin
      a_start = alloc_rd[AW-1];
      a_order = alloc_rd[ORDER_W-1:0];
      kf      = (a_order > ORDER_W'(PO)) ? ORDER_W'(PO) : a_order;
      fail    = op_ff ? (bad_ff | ~a_start) : (oom_ff | ~found);
      go_left = (node_rd & (MW'(1) << ot_ff)) != '0;

      stat.clear_done = &clr_ff;
      stat.is_free    = op_ff;
      stat.fail       = fail;
      stat.at_target  = (ot_c == ORDER_W'(PO));
      stat.desc_done  = (o_ff - ORDER_W'(1)) == ot_ff;
      stat.at_root    = (cur_ff == NW'(1));
   end

   // Leaf node and block of the booked allocation.
   logic [NW-1:0]       leaf_a, leaf_f, leaf;
   logic [NW+BW-1:0]    leaf_sh;
   logic [BW-1:0]       blk_a;
   logic [SHW-1:0]      off_wide;
   logic [FCW-1:0]      fc_next;
   logic [FCW+FREE_W-1:0] fc_x, fc_next_x;
   always_comb begin
      leaf_a    = cur_ff << (ot_ff - k_ff);
      leaf_f    = (NW'(1) << (ORDER_W'(PO) - k_ff)) + NW'(blk_ff >> k_ff);
      leaf      = op_ff ? leaf_f : leaf_a;
      leaf_sh   = (NW + BW)'(leaf_a) << k_ff;
      blk_a     = leaf_sh[BW-1:0];
      off_wide  = SHW'(blk_a) << block_shift;
      fc_next   = op_ff ? fc_ff + (FCW'(1) << k_ff) : fc_ff - (FCW'(1) << k_ff);
      fc_x      = {{FREE_W{1'b0}}, fc_ff};
      fc_next_x = {{FREE_W{1'b0}}, fc_next};
   end

   // Walk toward the root: split siblings, merges, summary masks.
   logic [MW-1:0] onehot_o, sib_val, parent_val;
   logic          in_split, merge_in;
   always_comb begin
      onehot_o = MW'(1) << o_ff;
      in_split = ~op_ff && (o_ff < ot_ff);
      sib_val  = in_split ? onehot_o : node_rd;
      if (merge_ff && ((sib_val & onehot_o) != '0)) begin
         parent_val = MW'(1) << (o_ff + ORDER_W'(1));
         merge_in   = 1'b1;
      end else begin
         parent_val = val_ff | sib_val;
         merge_in   = 1'b0;
      end
   end

   // Memory port selection.
   always_comb begin
      node_we = 1'b0;
      node_wa = cur_ff;
      node_wd = val_ff;
      node_ra = cur_ff ^ NW'(1);
      if (cmd.clear) begin
         node_we = 1'b1;
         node_wa = clr_ff;
         node_wd = (clr_ff == NW'(1)) ? (MW'(1) << PO) : '0;
      end
      if (cmd.uwrite) node_we = 1'b1;
      if (cmd.usib && in_split) begin
         node_we = 1'b1;
         node_wa = cur_ff ^ NW'(1);
         node_wd = onehot_o;
      end
      if (cmd.look)  node_ra = NW'(1);
      if (cmd.dread) node_ra = cur_ff << 1;

      alloc_we = (cmd.clear && !clr_ff[NW-1]) || cmd.book;
      alloc_wa = cmd.clear ? clr_ff[BW-1:0] : (op_ff ? blk_ff : blk_a);
      alloc_wd = (cmd.clear || op_ff) ? '0 : {1'b1, k_ff};
   end

   // Control state: clearing sweep and free block count.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         fc_ff  <= FCW'(POOL_BLOCKS);
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + NW'(1);
         if (cmd.book)  fc_ff  <= fc_next;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         bytes_ff <= req_request_bytes;
         off_ff   <= req_free_offset;
      end
      if (cmd.prep) begin
         k_ff   <= kfull[ORDER_W-1:0];
         oom_ff <= kfull > 5'(PO);
         bad_ff <= ((off_ff & low_mask) != '0) | oob;
         blk_ff <= shifted[BW-1:0];
      end
      if (cmd.check) begin
         cur_ff <= NW'(1);
         o_ff   <= ORDER_W'(PO);
         ot_ff  <= ot_c;
         if (op_ff) k_ff <= kf;
         if (fail) begin
            stat_ff  <= op_ff ? STAT_NOT_ALLOC : STAT_OOM;
            goff_ff  <= '0;
            gord_ff  <= '0;
            gfree_ff <= fc_x[FREE_W-1:0];
         end
      end
      if (cmd.ddata) begin
         cur_ff <= {cur_ff[NW-2:0], ~go_left};
         o_ff   <= o_ff - ORDER_W'(1);
      end
      if (cmd.book) begin
         cur_ff   <= leaf;
         o_ff     <= k_ff;
         val_ff   <= op_ff ? (MW'(1) << k_ff) : '0;
         merge_ff <= op_ff;
         stat_ff  <= STAT_OK;
         goff_ff  <= op_ff ? off_ff : off_wide[BYTE_W-1:0];
         gord_ff  <= k_ff;
         gfree_ff <= fc_next_x[FREE_W-1:0];
      end
      if (cmd.usib) begin
         val_ff   <= parent_val;
         merge_ff <= merge_in;
         cur_ff   <= cur_ff >> 1;
         o_ff     <= o_ff + ORDER_W'(1);
      end
   end

   assign rsp_status         = stat_ff;
   assign rsp_granted_offset = goff_ff;
   assign rsp_granted_order  = gord_ff;
   assign rsp_free_blocks    = gfree_ff;
endmodule

@@ hdl/buddy_block_allocator.sv @@
// Channel   Direction  Beat
// req_ch    in         op, request_bytes, free_offset
// rsp_ch    out        status, granted_offset, granted_order, free_blocks
// APB       in/out     block_shift register at byte address 0
//
// One item at a time. An allocate descends the tree from the root to the
// found order and then walks back up from the granted order; a free walks up
// from the freed order. The tree walks go over the single read port of the
// node memory. After reset a clearing pass runs before the first request is
// taken. A stalled result holds the block.
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bba_req_if.sink               req_ch,
   bba_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);
   logic [SHIFT_W-1:0] block_shift_ff;
   logic               csr_wr;
   dp_cmd_type         cmd;
   dp_stat_type        stat;

   // Configuration register.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SHIFT);
   assign prdata = (paddr[2] == REG_BLOCK_SHIFT) ? APB_DATA_W'(block_shift_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset)       block_shift_ff <= SHIFT_RESET;
      else if (csr_wr) block_shift_ff <= pwdata[SHIFT_W-1:0];
   end

   bba_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .stat(stat), .cmd(cmd)
   );

   bba_dp #(.POOL_BLOCKS(POOL_BLOCKS)) u_dp (
      .clock(clock), .reset(reset), .block_shift(block_shift_ff),
      .req_op(req_ch.op), .req_request_bytes(req_ch.request_bytes),
      .req_free_offset(req_ch.free_offset),
      .cmd(cmd), .stat(stat),
      .rsp_status(rsp_ch.status), .rsp_granted_offset(rsp_ch.granted_offset),
      .rsp_granted_order(rsp_ch.granted_order), .rsp_free_blocks(rsp_ch.free_blocks)
   );

   // The block never takes a request while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a result is pending");

   // A delivered result frees the block for the next request.
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> !rsp_ch.valid && req_ch.ready)
      else $error("result not retired after its beat");

   // Failed operations report a zero offset and order.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STAT_OK) |->
         (rsp_ch.granted_offset == '0 && rsp_ch.granted_order == '0))
      else $error("failed result carries an offset");

   // A register write lands in the block size register.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> block_shift_ff == $past(pwdata[SHIFT_W-1:0]))
      else $error("block size write lost");
endmodule
